@@ rtl/aemt_pkg.sv @@
// ----------------------------------------------------------------------------
// aemt_pkg
// Shared types and sizes for the actuator clearance envelope table.
// ----------------------------------------------------------------------------
package aemt_pkg;

	localparam int NUM_ACTUATORS      = 32;
	localparam int SLOTS_PER_ACTUATOR = 8;
	localparam int OFFSET_BITS        = 12;

	// one cell per slot of the table
	localparam int TABLE_SIZE = NUM_ACTUATORS * SLOTS_PER_ACTUATOR;

	// stored clearance width: offsets arrive as 12 bits and are kept to OFFSET_BITS
	localparam int STORE_BITS = (OFFSET_BITS < 12) ? OFFSET_BITS : 12;

	typedef logic [STORE_BITS-1:0] off_t;

	typedef enum logic [1:0] {
		KIND_DEFINE = 2'd0,
		KIND_SET    = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_MATCH  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  actuator;
		logic [7:0]  slot;
		logic [7:0]  command_code;
		logic        active_flag;
		logic [11:0] left_offset;
		logic [11:0] right_offset;
		logic [11:0] front_offset;
		logic [11:0] back_offset;
	} in_item_t;

	typedef struct packed {
		logic [11:0] left_total;
		logic [11:0] right_total;
		logic [11:0] front_total;
		logic [11:0] back_total;
	} out_item_t;

	typedef struct packed {
		off_t left;
		off_t right;
		off_t front;
		off_t back;
	} offs_t;

	// what travels from cell to cell along with the walk token
	typedef struct packed {
		logic  found;
		offs_t peak;
	} wave_t;

	typedef enum logic [1:0] {
		AEMT_IDLE,
		AEMT_WALK,
		AEMT_HOLD
	} state_t;

endpackage

@@ rtl/aemt_cell.sv @@
// ----------------------------------------------------------------------------
// aemt_cell
// One table slot: applies the current item when the walk token passes and
// folds its clearances into the running per-side maximum.
// ----------------------------------------------------------------------------
module aemt_cell import aemt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic [7:0] own_act,
	input  logic [7:0] own_slot,
	input  logic     wave_valid_in,
	input  wave_t    wave_in,
	output logic     wave_valid_out,
	output wave_t    wave_out
);

	offs_t      off_q;
	logic [7:0] cmd_q;
	logic       def_q;
	logic       act_q;
	logic       wave_valid_q;
	wave_t      wave_q;

	logic  hit_act;
	logic  hit_slot;
	logic  code_hit;
	logic  write_slot;
	logic  def_nxt;
	logic  act_nxt;
	logic  found_nxt;
	logic  contrib;
	offs_t peak_nxt;

	// slot update for the item in flight
	always_comb begin
		hit_act    = (item.actuator == own_act);
		hit_slot   = hit_act && (item.slot == own_slot);
		code_hit   = def_q && (cmd_q == item.command_code);
		write_slot = 1'b0;
		def_nxt    = def_q;
		act_nxt    = act_q;
		found_nxt  = wave_in.found;
		if (wave_valid_in) begin
			unique case (item.kind)
				KIND_DEFINE: begin
					if (hit_slot) begin
						write_slot = 1'b1;
						def_nxt    = 1'b1;
						act_nxt    = 1'b0;
					end
				end
				KIND_SET: begin
					if (hit_slot) act_nxt = item.active_flag;
				end
				KIND_CLEAR: begin
					if (hit_act) act_nxt = 1'b0;
				end
				KIND_MATCH: begin
					// first defined slot with this code wins
					if (hit_act) begin
						act_nxt   = code_hit && !wave_in.found;
						found_nxt = wave_in.found || code_hit;
					end
				end
				default: ;
			endcase
		end
	end

	// running maximum; a freshly defined slot is inactive so old offsets suffice
	always_comb begin
		contrib  = act_nxt && def_nxt;
		peak_nxt = wave_in.peak;
		if (contrib) begin
			if (off_q.left  > wave_in.peak.left)  peak_nxt.left  = off_q.left;
			if (off_q.right > wave_in.peak.right) peak_nxt.right = off_q.right;
			if (off_q.front > wave_in.peak.front) peak_nxt.front = off_q.front;
			if (off_q.back  > wave_in.peak.back)  peak_nxt.back  = off_q.back;
		end
	end

	// marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_q        <= 1'b0;
			act_q        <= 1'b0;
			wave_valid_q <= 1'b0;
		end else begin
			def_q        <= def_nxt;
			act_q        <= act_nxt;
			wave_valid_q <= wave_valid_in;
		end
	end

	// slot contents, no reset: read only once defined
	always_ff @(posedge clk) begin
		if (write_slot) begin
			off_q.left  <= STORE_BITS'(item.left_offset);
			off_q.right <= STORE_BITS'(item.right_offset);
			off_q.front <= STORE_BITS'(item.front_offset);
			off_q.back  <= STORE_BITS'(item.back_offset);
			cmd_q       <= item.command_code;
		end
	end

	// hand-off to the next cell
	always_ff @(posedge clk) begin
		if (wave_valid_in) begin
			wave_q.found <= found_nxt;
			wave_q.peak  <= peak_nxt;
		end
	end

	assign wave_valid_out = wave_valid_q;
	assign wave_out       = wave_q;

endmodule

@@ rtl/active_envelope_max_table_top.sv @@
// A reporting item's result passes the launch register, each slot cell's hand-off register
// in table order and the output register; a result behind a stalled output is parked first.
// No new item is taken until the previous token has walked every slot cell, nor while a
// result waits on a stalled output. An item with an out-of-range actuator, or a define or
// set item with an out-of-range slot, is dropped.
// Reset: arst_n clears all defined and active marks at once; offsets and codes stay
// unknown until a slot is defined. No clearing pass.
// ----------------------------------------------------------------------------
// active_envelope_max_table_top
// Clearance envelope table: a row of slot cells walked by one token per item,
// collecting the per-side maximum over active, defined slots.
// ----------------------------------------------------------------------------
module active_envelope_max_table_top import aemt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	state_t   state_q;
	state_t   state_nxt;
	in_item_t item_q;
	logic     rep_q;
	logic     start_q;
	offs_t    res_q;
	logic     rsp_valid_q;
	out_item_t rsp_q;

	logic [TABLE_SIZE:0] tok_valid;
	wave_t               wave [TABLE_SIZE+1];

	logic accept;
	logic act_ok;
	logic slot_ok;
	logic needs_slot;
	logic launch;
	logic tail;
	logic tail_rep;
	logic out_free;
	logic load_tail;
	logic load_hold;

	// range filter on the incoming item
	always_comb begin
		accept     = req_valid && !req_stall;
		act_ok     = ({1'b0, req.actuator} < 9'(NUM_ACTUATORS));
		slot_ok    = ({1'b0, req.slot} < 9'(SLOTS_PER_ACTUATOR));
		needs_slot = (req.kind == KIND_DEFINE) || (req.kind == KIND_SET);
		launch     = accept && act_ok && (!needs_slot || slot_ok);
	end

	assign tail     = tok_valid[TABLE_SIZE];
	assign tail_rep = tail && rep_q;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			AEMT_IDLE: if (launch) state_nxt = AEMT_WALK;
			AEMT_WALK: begin
				if (tail) state_nxt = (tail_rep && !out_free) ? AEMT_HOLD : AEMT_IDLE;
			end
			AEMT_HOLD: if (!rsp_stall) state_nxt = AEMT_IDLE;
			default:   state_nxt = AEMT_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_stall = (state_q != AEMT_IDLE);
		load_tail = (state_q == AEMT_WALK) && tail_rep && out_free;
		load_hold = (state_q == AEMT_HOLD) && !rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= AEMT_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= launch;
			if (load_tail || load_hold) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item held for the whole walk
	always_ff @(posedge clk) begin
		if (launch) begin
			item_q <= req;
			rep_q  <= (req.kind == KIND_SET) || (req.kind == KIND_MATCH);
		end
	end

	// result parking and output register
	always_ff @(posedge clk) begin
		if (tail_rep) res_q <= wave[TABLE_SIZE].peak;
		if (load_tail) begin
			rsp_q.left_total  <= 12'(wave[TABLE_SIZE].peak.left);
			rsp_q.right_total <= 12'(wave[TABLE_SIZE].peak.right);
			rsp_q.front_total <= 12'(wave[TABLE_SIZE].peak.front);
			rsp_q.back_total  <= 12'(wave[TABLE_SIZE].peak.back);
		end else if (load_hold) begin
			rsp_q.left_total  <= 12'(res_q.left);
			rsp_q.right_total <= 12'(res_q.right);
			rsp_q.front_total <= 12'(res_q.front);
			rsp_q.back_total  <= 12'(res_q.back);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// head of the chain: token enters with nothing found and zero peak
	assign tok_valid[0] = start_q;
	assign wave[0]      = '0;

	// slot cells, in table order
	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
		localparam int CellAct  = g / SLOTS_PER_ACTUATOR;
		localparam int CellSlot = g % SLOTS_PER_ACTUATOR;

		aemt_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.item           (item_q),
			.own_act        (8'(CellAct)),
			.own_slot       (8'(CellSlot)),
			.wave_valid_in  (tok_valid[g]),
			.wave_in        (wave[g]),
			.wave_valid_out (tok_valid[g+1]),
			.wave_out       (wave[g+1])
		);
	end

`ifndef SYNTHESIS
	// only one item walks the chain at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one walk token in the chain");

	// no token in flight while taking items
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == AEMT_IDLE) |-> (tok_valid == '0))
		else $error("walk token present in idle");

	// a parked result only exists behind a full, stalled output
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == AEMT_HOLD) |-> rsp_valid_q)
		else $error("result parked with empty output register");

	// a new result comes only from the chain tail or the parked result
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(load_tail || load_hold))
		else $error("result item without a source");
`endif

endmodule

@@ dv/active_envelope_max_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// active_envelope_max_table_top_tb
// Self-checking bench for the actuator clearance envelope table. A local
// shadow copy of the slot table follows every accepted item and predicts the
// per-side maximum clearance that each set or match item reports. Directed
// cases come first, then weighted random traffic with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module active_envelope_max_table_top_tb import aemt_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1200;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = TABLE_SIZE + 40;
	localparam int PRINT_CAP    = 50;
	// clearances are kept to OFFSET_BITS
	localparam logic [11:0] KEEP_MASK = 12'((1 << OFFSET_BITS) - 1);

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	in_item_t  req;
	logic      rsp_valid;
	logic      rsp_stall;
	out_item_t rsp;

	// shadow of the slot table
	offs_t      clear_tab   [TABLE_SIZE];
	logic [7:0] code_tab    [TABLE_SIZE];
	bit         defined_tab [TABLE_SIZE];
	bit         active_tab  [TABLE_SIZE];

	out_item_t envelope_q[$];
	int        miss_count   = 0;
	int        quiet_cycles = 0;
	int        hold_left    = 0;
	bit        steady       = 1'b0;

	always #2 clk = ~clk;

	active_envelope_max_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// idle cycles before the next item or result; none during steady stretches
	function automatic int draw_wait();
		return steady ? 0 : int'($urandom_range(0, 13));
	endfunction

	// per-side maximum over slots that are both active and defined
	function automatic out_item_t table_envelope();
		out_item_t peak;
		peak = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (active_tab[i] && defined_tab[i]) begin
				if (clear_tab[i].left > peak.left_total) peak.left_total = clear_tab[i].left;
				if (clear_tab[i].right > peak.right_total) peak.right_total = clear_tab[i].right;
				if (clear_tab[i].front > peak.front_total) peak.front_total = clear_tab[i].front;
				if (clear_tab[i].back > peak.back_total) peak.back_total = clear_tab[i].back;
			end
		end
		return peak;
	endfunction

	// update the shadow table; returns 1 when the item reports totals
	function automatic bit apply_item(input in_item_t it, output out_item_t totals);
		int base;
		int idx;
		totals = '0;
		if (it.actuator >= NUM_ACTUATORS) return 1'b0;
		base = it.actuator * SLOTS_PER_ACTUATOR;
		case (it.kind)
			KIND_DEFINE, KIND_SET: begin
				if (it.slot >= SLOTS_PER_ACTUATOR) return 1'b0;
				idx = base + it.slot;
				if (it.kind == KIND_DEFINE) begin
					clear_tab[idx] = '{left:  off_t'(it.left_offset & KEEP_MASK),
						right: off_t'(it.right_offset & KEEP_MASK),
						front: off_t'(it.front_offset & KEEP_MASK),
						back:  off_t'(it.back_offset & KEEP_MASK)};
					code_tab[idx]    = it.command_code;
					defined_tab[idx] = 1'b1;
					active_tab[idx]  = 1'b0;
					return 1'b0;
				end
				active_tab[idx] = it.active_flag;
			end
			default: begin
				for (int s = 0; s < SLOTS_PER_ACTUATOR; s++) active_tab[base + s] = 1'b0;
				if (it.kind == KIND_CLEAR) return 1'b0;
				// first defined slot with the same code wins
				for (int s = 0; s < SLOTS_PER_ACTUATOR; s++) begin
					if (defined_tab[base + s] && code_tab[base + s] == it.command_code) begin
						active_tab[base + s] = 1'b1;
						break;
					end
				end
			end
		endcase
		totals = table_envelope();
		return 1'b1;
	endfunction

	task automatic report_miss(input string what);
		miss_count++;
		if (miss_count <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic check_envelope(input out_item_t got);
		out_item_t want;
		if (envelope_q.size() == 0) begin
			report_miss($sformatf("result %h with nothing expected", got));
			return;
		end
		want = envelope_q.pop_front();
		if (got.left_total !== want.left_total)
			report_miss($sformatf("left_total %h, expected %h", got.left_total, want.left_total));
		if (got.right_total !== want.right_total)
			report_miss($sformatf("right_total %h, expected %h", got.right_total,
				want.right_total));
		if (got.front_total !== want.front_total)
			report_miss($sformatf("front_total %h, expected %h", got.front_total,
				want.front_total));
		if (got.back_total !== want.back_total)
			report_miss($sformatf("back_total %h, expected %h", got.back_total, want.back_total));
	endtask

	// drive one item and wait for it to be taken; valid stays high between
	// back-to-back items
	task automatic send_item(input in_item_t it);
		int gap;
		out_item_t totals;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (apply_item(it, totals)) envelope_q.push_back(totals);
	endtask

	// random content in every field; callers overwrite what they use
	function automatic in_item_t noise_item();
		in_item_t it;
		it.kind         = kind_t'($urandom_range(0, 3));
		it.actuator     = 8'($urandom());
		it.slot         = 8'($urandom());
		it.command_code = 8'($urandom());
		it.active_flag  = 1'($urandom());
		it.left_offset  = 12'($urandom());
		it.right_offset = 12'($urandom());
		it.front_offset = 12'($urandom());
		it.back_offset  = 12'($urandom());
		return it;
	endfunction

	task automatic define_slot(input int act, slt, code, input logic [11:0] l, r, f, b);
		in_item_t it;
		it = noise_item();
		it.kind         = KIND_DEFINE;
		it.actuator     = 8'(act);
		it.slot         = 8'(slt);
		it.command_code = 8'(code);
		it.left_offset  = l;
		it.right_offset = r;
		it.front_offset = f;
		it.back_offset  = b;
		send_item(it);
	endtask

	task automatic mark_slot(input int act, slt, input logic flag);
		in_item_t it;
		it = noise_item();
		it.kind        = KIND_SET;
		it.actuator    = 8'(act);
		it.slot        = 8'(slt);
		it.active_flag = flag;
		send_item(it);
	endtask

	task automatic match_code(input int act, code);
		in_item_t it;
		it = noise_item();
		it.kind         = KIND_MATCH;
		it.actuator     = 8'(act);
		it.command_code = 8'(code);
		send_item(it);
	endtask

	task automatic clear_marks(input int act);
		in_item_t it;
		it = noise_item();
		it.kind     = KIND_CLEAR;
		it.actuator = 8'(act);
		send_item(it);
	endtask

	// nothing defined yet: a mark on an undefined slot counts as zero,
	// a match with no defined slot still reports
	task automatic test_empty_table();
		mark_slot(0, 0, 1'b1);
		match_code(0, 0);
	endtask

	// corner slots with all-zero and all-one clearances and codes
	task automatic test_extremes();
		define_slot(0, 0, 8'h00, 12'h000, 12'h000, 12'h000, 12'h000);
		define_slot(NUM_ACTUATORS - 1, SLOTS_PER_ACTUATOR - 1, 8'hFF,
			12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		mark_slot(0, 0, 1'b1);
		mark_slot(NUM_ACTUATORS - 1, SLOTS_PER_ACTUATOR - 1, 1'b1);
		define_slot(5, 3, 8'h5A, 12'hA5C, 12'h3C1, 12'h800, 12'h07F);
		mark_slot(5, 3, 1'b1);
		mark_slot(NUM_ACTUATORS - 1, SLOTS_PER_ACTUATOR - 1, 1'b0);
	endtask

	// actuator out of range for every kind, slot out of range for define and set
	task automatic test_ignored_items();
		in_item_t it;
		int far_act [4] = '{NUM_ACTUATORS, 255, 128, 64};
		for (int k = 0; k < 4; k++) begin
			it = noise_item();
			it.kind     = kind_t'(k);
			it.actuator = 8'(far_act[k]);
			send_item(it);
		end
		define_slot(5, SLOTS_PER_ACTUATOR, 8'h00, 12'h001, 12'h001, 12'h001, 12'h001);
		it = noise_item();
		it.kind        = KIND_SET;
		it.actuator    = 8'd5;
		it.slot        = 8'hFF;
		it.active_flag = 1'b0;
		send_item(it);
		mark_slot(5, 3, 1'b1);
	endtask

	// redefining an active slot drops its mark
	task automatic test_redefine();
		define_slot(5, 3, 8'h11, 12'h001, 12'h002, 12'h003, 12'h004);
		mark_slot(0, 0, 1'b1);
		mark_slot(5, 3, 1'b1);
	endtask

	// first match wins, no match leaves the actuator clear, clear has no result
	task automatic test_match();
		define_slot(2, 1, 8'h33, 12'h064, 12'h0C8, 12'h12C, 12'h190);
		define_slot(2, 4, 8'h33, 12'hFA0, 12'hFA0, 12'hFA0, 12'hFA0);
		match_code(2, 8'h33);
		match_code(5, 8'h77);
		clear_marks(2);
		match_code(2, 8'h99);
	endtask

	function automatic logic [11:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return 12'h000;
			1: return 12'hFFF;
			default: return 12'($urandom());
		endcase
	endfunction

	// mostly well-formed traffic on a few actuators and codes so that
	// defines, marks and matches interact; some out-of-range noise
	task automatic test_random_traffic();
		in_item_t it;
		int counted;
		int pick;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			steady = ((counted / 100) % 4) == 3;
			it = noise_item();
			pick = $urandom_range(0, 99);
			if (pick < 35) it.kind = KIND_DEFINE;
			else if (pick < 65) it.kind = KIND_SET;
			else if (pick < 75) it.kind = KIND_CLEAR;
			else it.kind = KIND_MATCH;
			pick = $urandom_range(0, 99);
			if (pick < 6) it.actuator = 8'($urandom_range(0, 255));
			else if (pick < 70) it.actuator = 8'($urandom_range(0, 3));
			else it.actuator = 8'($urandom_range(0, NUM_ACTUATORS - 1));
			if ($urandom_range(0, 99) >= 5)
				it.slot = 8'($urandom_range(0, SLOTS_PER_ACTUATOR - 1));
			if ($urandom_range(0, 9) < 8) it.command_code = 8'($urandom_range(0, 7));
			it.left_offset  = pick_offset();
			it.right_offset = pick_offset();
			it.front_offset = pick_offset();
			it.back_offset  = pick_offset();
			if (it.actuator < NUM_ACTUATORS && (it.kind == KIND_CLEAR ||
				it.kind == KIND_MATCH || it.slot < SLOTS_PER_ACTUATOR))
				counted++;
			send_item(it);
		end
		steady = 1'b0;
	endtask

	// result side: after each taken result, stall may be raised ahead of the next one and held for a
	// drawn number of cycles while a result waits
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			check_envelope(rsp);
			hold_left = draw_wait();
		end else if (rsp_valid && hold_left > 0) begin
			hold_left--;
		end
		rsp_stall <= (hold_left > 0);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("active_envelope_max_table_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_stall = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_extremes();
		test_ignored_items();
		test_redefine();
		test_match();
		test_random_traffic();
		req_valid <= 1'b0;

		// wait out the remaining results, then a full walk for strays
		while (envelope_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (miss_count == 0) begin
			$display("active_envelope_max_table_top verification clean");
		end else begin
			$display("active_envelope_max_table_top verification failed");
		end
		$finish;
	end

endmodule
